// File: sv/rbsi_pkg.sv
// Shared types, constants and binary32 helper functions for the ray/box slab unit.
// Depends on nothing; every other file of the block imports it.
package rbsi_pkg;

    localparam logic [31:0] MISS_BITS   = 32'hBF800000;
    localparam logic [31:0] QNAN_BITS   = 32'h7FC00000;
    localparam logic [31:0] DIV_RESET   = 32'h358637BD;

    localparam int AXES       = 3;
    localparam int SUB_LAT    = 3;
    localparam int DIV_STAGES = 13;
    localparam int DIV_LAT    = DIV_STAGES + 4;
    localparam int PIPE_LAT   = 1 + SUB_LAT + DIV_LAT + 3;

    localparam logic REG_DIVISOR = 1'b0;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sgn;
    } fcls_t;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic       done;
        n    = '0;
        done = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!done) begin
                if (v[i]) begin
                    done = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic f_isnan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] f_key(input logic [31:0] a);
        return a[31] ? ~a : {1'b1, a[30:0]};
    endfunction

    function automatic logic [31:0] f_min(input logic [31:0] a, input logic [31:0] b);
        if (f_isnan(a)) begin
            return b;
        end
        if (f_isnan(b)) begin
            return a;
        end
        return (f_key(a) <= f_key(b)) ? a : b;
    endfunction

    function automatic logic [31:0] f_max(input logic [31:0] a, input logic [31:0] b);
        if (f_isnan(a)) begin
            return b;
        end
        if (f_isnan(b)) begin
            return a;
        end
        return (f_key(a) >= f_key(b)) ? a : b;
    endfunction

    function automatic logic f_neg(input logic [31:0] a);
        return !f_isnan(a) && a[31] && (a[30:0] != 31'd0);
    endfunction

    function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
        return !f_isnan(a) && !f_isnan(b) && !((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            && (f_key(a) > f_key(b));
    endfunction

endpackage

// File: sv/rbsi_fsub.sv
// Three-stage binary32 subtractor (a - b), round to nearest even, with subnormals.
// Depends on rbsi_pkg for the leading-zero count and constants.
module rbsi_fsub (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import rbsi_pkg::*;

    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap, lost;
    logic [7:0]  ea, eb, xa, xb, ex, ey, dd;
    logic [23:0] ma, mb, mx, my;
    logic [4:0]  dc;
    logic [26:0] yext, ysh;

    logic        s1_sx_reg, s1_sub_reg, s1_nan_reg, s1_inf_reg, s1_isg_reg;
    logic [7:0]  s1_ex_reg;
    logic [26:0] s1_x_reg, s1_y_reg;

    always_comb begin
        sa    = a[31];
        sb    = ~b[31];
        ea    = a[30:23];
        eb    = b[30:23];
        a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        ma    = {ea != 8'd0, a[22:0]};
        mb    = {eb != 8'd0, b[22:0]};
        xa    = (ea == 8'd0) ? 8'd1 : ea;
        xb    = (eb == 8'd0) ? 8'd1 : eb;
        swap  = {xb, mb} > {xa, ma};
        ex    = swap ? xb : xa;
        ey    = swap ? xa : xb;
        mx    = swap ? mb : ma;
        my    = swap ? ma : mb;
        dd    = ex - ey;
        dc    = (dd > 8'd27) ? 5'd27 : dd[4:0];
        yext  = {my, 3'b000};
        ysh   = yext >> dc;
        lost  = |(yext & ~({27{1'b1}} << dc));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sx_reg  <= swap ? sb : sa;
            s1_sub_reg <= sa ^ sb;
            s1_nan_reg <= a_nan | b_nan | (a_inf & b_inf & (sa ^ sb));
            s1_inf_reg <= a_inf | b_inf;
            s1_isg_reg <= a_inf ? sa : sb;
            s1_ex_reg  <= ex;
            s1_x_reg   <= {mx, 3'b000};
            s1_y_reg   <= {ysh[26:1], ysh[0] | lost};
        end
    end

    logic [27:0] sum_next;
    logic [5:0]  lz_full;

    logic        s2_sx_reg, s2_sub_reg, s2_nan_reg, s2_inf_reg, s2_isg_reg;
    logic [7:0]  s2_ex_reg;
    logic [27:0] s2_sum_reg;
    logic [4:0]  s2_lz_reg;

    always_comb begin
        if (s1_sub_reg) begin
            sum_next = {1'b0, s1_x_reg} - {1'b0, s1_y_reg};
        end else begin
            sum_next = {1'b0, s1_x_reg} + {1'b0, s1_y_reg};
        end
        lz_full = lzc32({sum_next[26:0], 5'b11111});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sx_reg  <= s1_sx_reg;
            s2_sub_reg <= s1_sub_reg;
            s2_nan_reg <= s1_nan_reg;
            s2_inf_reg <= s1_inf_reg;
            s2_isg_reg <= s1_isg_reg;
            s2_ex_reg  <= s1_ex_reg;
            s2_sum_reg <= sum_next;
            s2_lz_reg  <= lz_full[4:0];
        end
    end

    logic [7:0]  exm1, eenc;
    logic [4:0]  sh;
    logic [26:0] nrm;
    logic [8:0]  ex9;
    logic        rnd, ovf;
    logic [30:0] packed_val;
    logic [31:0] y_next;
    logic [31:0] y_reg;

    always_comb begin
        exm1 = s2_ex_reg - 8'd1;
        sh   = ({3'b000, s2_lz_reg} < exm1) ? s2_lz_reg : exm1[4:0];
        if (s2_sum_reg[27]) begin
            nrm = {s2_sum_reg[27:2], s2_sum_reg[1] | s2_sum_reg[0]};
            ex9 = {1'b0, s2_ex_reg} + 9'd1;
        end else begin
            nrm = s2_sum_reg[26:0] << sh;
            ex9 = {1'b0, s2_ex_reg} - {4'b0000, sh};
        end
        ovf        = nrm[26] && (ex9 >= 9'd255);
        eenc       = nrm[26] ? ex9[7:0] : 8'd0;
        rnd        = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
        packed_val = {eenc, nrm[25:3]} + {30'd0, rnd};
        if (s2_nan_reg) begin
            y_next = QNAN_BITS;
        end else if (s2_inf_reg) begin
            y_next = {s2_isg_reg, 8'hFF, 23'd0};
        end else if (s2_sum_reg == 28'd0) begin
            y_next = {~s2_sub_reg & s2_sx_reg, 31'd0};
        end else if (ovf) begin
            y_next = {s2_sx_reg, 8'hFF, 23'd0};
        end else begin
            y_next = {s2_sx_reg, packed_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: sv/rbsi_fdiv.sv
// Pipelined binary32 divider (n / d), restoring recurrence at two quotient bits per stage,
// round to nearest even with subnormals. Depends on rbsi_pkg.
module rbsi_fdiv (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] n,
    input  logic [31:0] d,
    output logic [31:0] q
);
    import rbsi_pkg::*;

    function automatic logic [25:0] dstep(input logic [24:0] r, input logic [23:0] m);
        logic [24:0] t;
        t = r - {1'b0, m};
        if (r >= {1'b0, m}) begin
            return {1'b1, t[23:0], 1'b0};
        end
        return {1'b0, r[23:0], 1'b0};
    endfunction

    logic [7:0]  en_raw, ed_raw, exn, exd;
    logic        n_nan, d_nan, n_inf, d_inf, n_zero, d_zero;
    logic [23:0] mn, md;
    logic [5:0]  lzn_full, lzd_full;
    fcls_t       cls_next;

    logic [23:0] p1_mn_reg, p1_md_reg;
    logic [7:0]  p1_exn_reg, p1_exd_reg;
    logic [4:0]  p1_lzn_reg, p1_lzd_reg;
    fcls_t       p1_cls_reg;

    always_comb begin
        en_raw        = n[30:23];
        ed_raw        = d[30:23];
        n_nan         = (en_raw == 8'hFF) && (n[22:0] != 23'd0);
        d_nan         = (ed_raw == 8'hFF) && (d[22:0] != 23'd0);
        n_inf         = (en_raw == 8'hFF) && (n[22:0] == 23'd0);
        d_inf         = (ed_raw == 8'hFF) && (d[22:0] == 23'd0);
        n_zero        = (n[30:0] == 31'd0);
        d_zero        = (d[30:0] == 31'd0);
        mn            = {en_raw != 8'd0, n[22:0]};
        md            = {ed_raw != 8'd0, d[22:0]};
        exn           = (en_raw == 8'd0) ? 8'd1 : en_raw;
        exd           = (ed_raw == 8'd0) ? 8'd1 : ed_raw;
        lzn_full      = lzc32({mn, 8'hFF});
        lzd_full      = lzc32({md, 8'hFF});
        cls_next.nan  = n_nan | d_nan | (n_zero & d_zero) | (n_inf & d_inf);
        cls_next.inf  = n_inf | d_zero;
        cls_next.zero = n_zero | d_inf;
        cls_next.sgn  = n[31] ^ d[31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_mn_reg  <= mn;
            p1_md_reg  <= md;
            p1_exn_reg <= exn;
            p1_exd_reg <= exd;
            p1_lzn_reg <= lzn_full[4:0];
            p1_lzd_reg <= lzd_full[4:0];
            p1_cls_reg <= cls_next;
        end
    end

    logic [23:0]        mnn, mdn;
    logic               lt;
    logic signed [10:0] e_next;

    logic [24:0]        r_reg   [0:DIV_STAGES];
    logic [25:0]        q_reg   [0:DIV_STAGES];
    logic [23:0]        md_reg  [0:DIV_STAGES];
    logic signed [10:0] e_reg   [0:DIV_STAGES];
    fcls_t              cls_reg [0:DIV_STAGES];

    always_comb begin
        mnn    = p1_mn_reg << p1_lzn_reg;
        mdn    = p1_md_reg << p1_lzd_reg;
        lt     = mnn < mdn;
        e_next = $signed({3'b000, p1_exn_reg}) - $signed({6'd0, p1_lzn_reg})
               - $signed({3'b000, p1_exd_reg}) + $signed({6'd0, p1_lzd_reg})
               + 11'sd127 - $signed({10'd0, lt});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= lt ? {mnn, 1'b0} : {1'b0, mnn};
            q_reg[0]   <= '0;
            md_reg[0]  <= mdn;
            e_reg[0]   <= e_next;
            cls_reg[0] <= p1_cls_reg;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_iter
        logic [25:0] st1, st2;
        assign st1 = dstep(r_reg[g], md_reg[g]);
        assign st2 = dstep(st1[24:0], md_reg[g]);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[g+1]   <= st2[24:0];
                q_reg[g+1]   <= {q_reg[g][23:0], st1[25], st2[25]};
                md_reg[g+1]  <= md_reg[g];
                e_reg[g+1]   <= e_reg[g];
                cls_reg[g+1] <= cls_reg[g];
            end
        end
    end

    logic signed [10:0] e_last, shv;
    logic [4:0]         sh;
    logic [7:0]         eenc_next;
    logic               ovf_next, lost;
    logic [26:0]        vq, wq;

    logic [26:0]        r1_w_reg;
    logic [7:0]         r1_eenc_reg;
    logic               r1_ovf_reg;
    fcls_t              r1_cls_reg;

    always_comb begin
        e_last = e_reg[DIV_STAGES];
        shv    = 11'sd1 - e_last;
        if (e_last <= 11'sd0) begin
            sh        = (shv > 11'sd31) ? 5'd31 : shv[4:0];
            eenc_next = 8'd0;
        end else begin
            sh        = 5'd0;
            eenc_next = e_last[7:0];
        end
        ovf_next = e_last >= 11'sd255;
        vq       = {q_reg[DIV_STAGES], r_reg[DIV_STAGES] != 25'd0};
        wq       = vq >> sh;
        lost     = |(vq & ~({27{1'b1}} << sh));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_w_reg    <= {wq[26:1], wq[0] | lost};
            r1_eenc_reg <= eenc_next;
            r1_ovf_reg  <= ovf_next;
            r1_cls_reg  <= cls_reg[DIV_STAGES];
        end
    end

    logic        rnd;
    logic [30:0] packed_val;
    logic [31:0] q_next;
    logic [31:0] q_out_reg;

    always_comb begin
        rnd        = r1_w_reg[2] & (r1_w_reg[1] | r1_w_reg[0] | r1_w_reg[3]);
        packed_val = {r1_eenc_reg, r1_w_reg[25:3]} + {30'd0, rnd};
        if (r1_cls_reg.nan) begin
            q_next = QNAN_BITS;
        end else if (r1_cls_reg.inf || (!r1_cls_reg.zero && r1_ovf_reg)) begin
            q_next = {r1_cls_reg.sgn, 8'hFF, 23'd0};
        end else if (r1_cls_reg.zero) begin
            q_next = {r1_cls_reg.sgn, 31'd0};
        end else begin
            q_next = {r1_cls_reg.sgn, packed_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_out_reg <= q_next;
        end
    end

    assign q = q_out_reg;

endmodule

// File: sv/ray_box_slab_intersect_unit.sv
// Ray against axis-aligned box by the slab method, binary32 throughout.
// One request per cycle is sustained while the output is not stalled.
// The pipeline depth is dominated by the dividers: 13 recurrence stages of two quotient bits each.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and loads the zero-direction divisor.
// Depends on rbsi_pkg, rbsi_fsub and rbsi_fdiv.
module ray_box_slab_intersect_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32 bits each)
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_distance
    output logic [31:0]  m_tdata,
    // hit
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rbsi_pkg::*;

    logic                adv;
    logic [31:0]         divisor_reg;
    logic [PIPE_LAT-1:0] vld_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DIVISOR) ? divisor_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DIV_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DIVISOR)) begin
            divisor_reg <= pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    logic [31:0] org_reg [0:AXES-1];
    logic [31:0] lo_reg  [0:AXES-1];
    logic [31:0] hi_reg  [0:AXES-1];
    logic [31:0] dvs_reg [0:AXES-1][0:SUB_LAT];
    logic [31:0] tlo     [0:AXES-1];
    logic [31:0] thi     [0:AXES-1];
    logic [31:0] dlo     [0:AXES-1];
    logic [31:0] dhi     [0:AXES-1];

    for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
        logic [31:0] dir;
        assign dir = s_tdata[(ax+3)*32 +: 32];

        always_ff @(posedge aclk) begin
            if (adv) begin
                org_reg[ax]    <= s_tdata[ax*32 +: 32];
                lo_reg[ax]     <= s_tdata[(ax+6)*32 +: 32];
                hi_reg[ax]     <= s_tdata[(ax+9)*32 +: 32];
                dvs_reg[ax][0] <= (dir[30:0] == 31'd0) ? divisor_reg : dir;
            end
        end

        for (genvar k = 0; k < SUB_LAT; k++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dvs_reg[ax][k+1] <= dvs_reg[ax][k];
                end
            end
        end

        rbsi_fsub u_sub_lo (.aclk(aclk), .en(adv), .a(lo_reg[ax]), .b(org_reg[ax]),
                            .y(dlo[ax]));
        rbsi_fsub u_sub_hi (.aclk(aclk), .en(adv), .a(hi_reg[ax]), .b(org_reg[ax]),
                            .y(dhi[ax]));
        rbsi_fdiv u_div_lo (.aclk(aclk), .en(adv), .n(dlo[ax]), .d(dvs_reg[ax][SUB_LAT]),
                            .q(tlo[ax]));
        rbsi_fdiv u_div_hi (.aclk(aclk), .en(adv), .n(dhi[ax]), .d(dvs_reg[ax][SUB_LAT]),
                            .q(thi[ax]));
    end

    logic [31:0] near_reg [0:AXES-1];
    logic [31:0] far_reg  [0:AXES-1];
    logic [31:0] entry_next, leave_next, entry_reg, leave_reg;
    logic        miss;
    logic [31:0] res;
    logic [31:0] dist_next, dist_reg;
    logic        hit_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < AXES; i++) begin
                near_reg[i] <= f_min(tlo[i], thi[i]);
                far_reg[i]  <= f_max(tlo[i], thi[i]);
            end
        end
    end

    always_comb begin
        entry_next = f_max(f_max(near_reg[0], near_reg[1]), near_reg[2]);
        leave_next = f_min(f_min(far_reg[0], far_reg[1]), far_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            entry_reg <= entry_next;
            leave_reg <= leave_next;
        end
    end

    always_comb begin
        miss = f_neg(leave_reg) || f_gt(entry_reg, leave_reg);
        res  = f_neg(entry_reg) ? leave_reg : entry_reg;
        if (miss) begin
            dist_next = MISS_BITS;
        end else if (f_isnan(res)) begin
            dist_next = QNAN_BITS;
        end else begin
            dist_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg  <= !miss;
            dist_reg <= dist_next;
        end
    end

    assign m_tdata    = dist_reg;
    assign m_tuser[0] = hit_reg;

endmodule

// File: sv/rbsi_checker.sv
// Port-level checks for the ray/box slab unit, attached to the top level by bind.
// Depends on rbsi_pkg and ray_box_slab_intersect_unit.
module rbsi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        pready
);
    import rbsi_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == MISS_BITS)
        else $error("miss without the miss distance");

    a_hitpos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !(m_tdata[31] && (m_tdata[30:0] != 31'd0)))
        else $error("hit with a negative distance");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready && (s_tvalid || !s_tvalid))
        else $error("configuration port not ready");

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_rbsi_checker (.*);
